### src/sha256_hasher_unit_macros.svh
// Assertion macros for the SHA-256 hasher.
`ifndef SHA256_HASHER_UNIT_MACROS_SVH
`define SHA256_HASHER_UNIT_MACROS_SVH
// implication checked on every clock edge outside reset
`define SHA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// implication whose consequent is checked in the next cycle
`define SHA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### src/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions shared by the SHA-256 hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} out_item_t;

	// front to back queue entry
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       last;
	} cmd_t;

	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] INIT_H [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PAD_BYTE = 8'h80;

	function automatic logic [31:0] ror(input logic [31:0] x, input int r);
		ror = (x >> r) | (x << (32 - r));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		ssig0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		ssig1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		bsig0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		bsig1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage

### src/sha_front.sv
// ----------------------------------------------------------------------------
// sha_front
// Accepts items, drops empty ones and queues the rest for the back end.
// ----------------------------------------------------------------------------
module sha_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sha_pkg::in_item_t in_item,
	output logic              q_valid,
	input  logic              q_pop,
	output sha_pkg::cmd_t     q_head
);

	sha_pkg::cmd_t           mem_q [sha_pkg::QDEPTH];
	logic [sha_pkg::QAW-1:0] wr_q, rd_q;
	logic [sha_pkg::QAW:0]   cnt_q;
	logic                    push;

	assign in_stall = (cnt_q == 3'(sha_pkg::QDEPTH));
	// an item with neither byte nor end mark does nothing
	assign push = in_valid && !in_stall && (in_item.byte_valid || in_item.last);
	assign q_valid = (cnt_q != '0);
	assign q_head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= '{data_byte: in_item.data_byte,
				byte_valid: in_item.byte_valid, last: in_item.last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (q_pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + {2'b0, push} - {2'b0, q_pop};
		end
	end

endmodule

### src/sha_back.sv
// ----------------------------------------------------------------------------
// sha_back
// Block buffer, 64-round compression engine, padding and digest output.
// ----------------------------------------------------------------------------
module sha_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_pop,
	input  sha_pkg::cmd_t      q_head,
	output logic               out_valid,
	input  logic               out_stall,
	output sha_pkg::out_item_t out_item
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PAD  = 3'd1;
	localparam logic [2:0] ST_RND  = 3'd2;
	localparam logic [2:0] ST_ADD  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;
	localparam logic [2:0] ST_PADM = 3'd5;

	logic [2:0]  st_q;
	logic [60:0] cnt_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic [5:0]  padi_q;
	logic        fin_q;     // finishing message
	logic        final_q;   // current compression is the length block
	logic        mark_q;    // end mark came with the byte that filled the block
	logic [2:0]  oidx_q;

	logic [5:0]  fill;
	logic [31:0] t1, t2, wnew, wcur;
	logic [63:0] bits;
	logic [7:0]  pad_val;
	logic        wr_en;
	logic [5:0]  wr_pos;
	logic [7:0]  wr_byte;

	assign fill = cnt_q[5:0];
	assign bits = {cnt_q, 3'b000};
	assign wcur = w_q[0];
	assign wnew = sha_pkg::ssig1(w_q[14]) + w_q[9] + sha_pkg::ssig0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + sha_pkg::bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha_pkg::ROUND_K[rnd_q] + wcur;
	assign t2 = sha_pkg::bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2])
		^ (v_q[1] & v_q[2]));

	// pad byte for position padi_q: length bytes only in the final block
	always_comb begin
		pad_val = 8'h00;
		if (final_q && padi_q >= 6'd56) pad_val = bits[{~padi_q[2:0], 3'b000} +: 8];
	end

	// one byte into the block per cycle; 0x80 marker goes where the next byte would land
	always_comb begin
		wr_en = 1'b0;
		wr_pos = fill;
		wr_byte = sha_pkg::PAD_BYTE;
		if (st_q == ST_IDLE) begin
			wr_en = q_valid;
			if (q_head.byte_valid) wr_byte = q_head.data_byte;
		end else if (st_q == ST_PADM) begin
			wr_en = 1'b1;
		end else if (st_q == ST_PAD) begin
			wr_en = 1'b1;
			wr_pos = padi_q;
			wr_byte = pad_val;
		end
	end

	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign out_valid = (st_q == ST_OUT);
	assign out_item = '{digest_word: h_q[oidx_q], word_index: oidx_q,
		last_word: (oidx_q == 3'd7)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			cnt_q <= '0;
			rnd_q <= '0;
			padi_q <= '0;
			fin_q <= 1'b0;
			final_q <= 1'b0;
			mark_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
		end else begin
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						if (q_head.byte_valid) begin
							cnt_q <= cnt_q + 61'd1;
							if (fill == 6'd63) begin
								rnd_q <= '0;
								final_q <= 1'b0;
								mark_q <= q_head.last;
								st_q <= ST_RND;
							end else if (q_head.last) begin
								// marker written next at fill+1
								st_q <= ST_PADM;
							end
						end else begin
							// end only: marker written now at fill
							fin_q <= 1'b1;
							final_q <= (fill < 6'd56);
							padi_q <= fill + 6'd1;
							if (fill == 6'd63) begin
								rnd_q <= '0;
								st_q <= ST_RND;
							end else st_q <= ST_PAD;
						end
					end
				end
				ST_PADM: begin
					// byte with last: now place marker
					fin_q <= 1'b1;
					final_q <= (fill < 6'd56);
					padi_q <= fill + 6'd1;
					if (fill == 6'd63) begin
						rnd_q <= '0;
						st_q <= ST_RND;
					end else st_q <= ST_PAD;
				end
				ST_PAD: begin
					padi_q <= padi_q + 6'd1;
					if (padi_q == 6'd63) begin
						rnd_q <= '0;
						st_q <= ST_RND;
					end
				end
				ST_RND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) st_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (mark_q) begin
						// block filled by the last byte: marker opens a new block
						mark_q <= 1'b0;
						st_q <= ST_PADM;
					end else if (!fin_q) st_q <= ST_IDLE;
					else if (final_q) begin
						oidx_q <= '0;
						st_q <= ST_OUT;
					end else begin
						// extra block: zeros then length
						final_q <= 1'b1;
						padi_q <= '0;
						st_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							st_q <= ST_IDLE;
							cnt_q <= '0;
							fin_q <= 1'b0;
							final_q <= 1'b0;
							for (int i = 0; i < 8; i++) h_q[i] <= sha_pkg::INIT_H[i];
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// round datapath; the schedule window holds the block bytes between rounds
	always_ff @(posedge clk) begin
		if (st_q != ST_RND) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			if (wr_en) w_q[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
		end else begin
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wnew;
		end
	end

endmodule

### src/sha256_hasher_unit.sv
// ----------------------------------------------------------------------------
// sha256_hasher_unit
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ----------------------------------------------------------------------------
//  channel | handshake             | payload
//  in      | in_valid / in_stall   | in_item  (data_byte, byte_valid, last)
//  out     | out_valid / out_stall | out_item (digest_word, word_index, last_word)
//
// The back end takes a byte item in its idle state; a full block adds 64 rounds
// and a feed-forward step. Bytes land straight in the 16-word schedule window.
// Finishing: a marker state for a byte with the end mark, a zero/length fill
// sweep to the end of each block (two blocks when 56+ bytes remain), the rounds
// and feed-forward per block, then the eight output words. A four-entry queue stalls
// the input when full. Reset loads the initial hash values; out_stall holds a word.
module sha256_hasher_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  sha_pkg::in_item_t   in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output sha_pkg::out_item_t  out_item
);

	`include "sha256_hasher_unit_macros.svh"

	logic          q_valid, q_pop;
	sha_pkg::cmd_t q_head;

	sha_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head)
	);

	sha_back u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_pop(q_pop), .q_head(q_head),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	`SHA_ASSERT_IMP(a_pop_needs_data, q_pop, q_valid, "pop from empty queue")
	`SHA_ASSERT_IMP(a_last_idx, out_valid && out_item.last_word,
		out_item.word_index == 3'd7, "last_word off word 7")
	`SHA_ASSERT_NXT(a_idx_step, out_valid && !out_stall && !out_item.last_word,
		out_valid && out_item.word_index == $past(out_item.word_index) + 3'd1,
		"digest word skipped")

endmodule

### tb/sha256_hasher_checker.sv
// ----------------------------------------------------------------------------
// sha256_hasher_checker
// Watches both channels of the hasher, predicts each digest from the accepted
// bytes and compares every output word with the oldest prediction.
// ----------------------------------------------------------------------------
module sha256_hasher_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  sha_pkg::in_item_t  in_item,
	input  logic               out_valid,
	input  logic               out_stall,
	input  sha_pkg::out_item_t out_item,
	output int                 errors,
	output int                 pending,
	output int                 digests
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [31:0] K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};
	localparam logic [31:0] H0 [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	logic [31:0] hash_state [8];
	logic [7:0]  block_buf [64];
	logic [60:0] msg_len;
	sha_pkg::out_item_t digest_q[$];

	function automatic logic [31:0] rotr(logic [31:0] x, int r);
		return (x >> r) | (x << (32 - r));
	endfunction

	task automatic compress();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2;
		for (int i = 0; i < 16; i++)
			w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
		for (int i = 16; i < 64; i++)
			w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
				+ (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
		v = hash_state;
		for (int i = 0; i < 64; i++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[i] + w[i];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++)
			hash_state[i] += v[i];
	endtask

	task automatic absorb_item(sha_pkg::in_item_t it);
		int fill;
		logic [63:0] bits;
		sha_pkg::out_item_t o;
		if (it.byte_valid) begin
			fill = msg_len[5:0];
			block_buf[fill] = it.data_byte;
			msg_len++;
			if (fill == 63)
				compress();
		end
		if (it.last) begin
			fill = msg_len[5:0];
			block_buf[fill] = 8'h80;
			for (int i = fill + 1; i < 64; i++)
				block_buf[i] = '0;
			if (fill >= 56) begin
				compress();
				for (int i = 0; i < 64; i++)
					block_buf[i] = '0;
			end
			bits = {msg_len, 3'b000};
			for (int i = 0; i < 8; i++)
				block_buf[63-i] = bits[8*i +: 8];
			compress();
			for (int i = 0; i < 8; i++) begin
				o.digest_word = hash_state[i];
				o.word_index = 3'(i);
				o.last_word = (i == 7);
				digest_q.push_back(o);
			end
			hash_state = H0;
			msg_len = '0;
		end
	endtask

	initial begin
		errors = 0;
		digests = 0;
		pending = 0;
		hash_state = H0;
		msg_len = '0;
	end

	always @(posedge clk) begin
		sha_pkg::out_item_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (digest_q.size() == 0) begin
					$error("unexpected digest word %h", out_item.digest_word);
					errors++;
				end else begin
					e = digest_q.pop_front();
					if (out_item.digest_word !== e.digest_word) begin
						$error("digest_word: expected %h got %h", e.digest_word,
							out_item.digest_word);
						errors++;
					end
					if (out_item.word_index !== e.word_index) begin
						$error("word_index: expected %0d got %0d", e.word_index,
							out_item.word_index);
						errors++;
					end
					if (out_item.last_word !== e.last_word) begin
						$error("last_word: expected %0d got %0d", e.last_word,
							out_item.last_word);
						errors++;
					end
					if (e.last_word)
						digests++;
				end
			end
			if (in_valid && !in_stall)
				absorb_item(in_item);
		end
		pending = digest_q.size();
	end
endmodule

### tb/tb_sha256_hasher_unit.sv
// ----------------------------------------------------------------------------
// tb_sha256_hasher_unit
// Byte-stream stimulus for the SHA-256 hasher: directed messages around the
// padding boundaries, then random messages with idles and output stalls.
// ----------------------------------------------------------------------------
module tb_sha256_hasher_unit;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	sha_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	sha_pkg::out_item_t out_item;
	int errors, pending, digests;
	int n_items = 0;
	bit calm = 1'b0;	// no idling or stalls while set
	int len_list [5] = '{55, 56, 63, 64, 65};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	sha256_hasher_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	sha256_hasher_checker u_chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.errors(errors), .pending(pending), .digests(digests)
	);

	// random receiver stalls with a probability of about 12 percent
	always @(posedge clk)
		out_stall <= !calm && ($urandom_range(99) < 12);

	// one item: random idle gaps first, then hold until accepted
	task automatic send_item(logic [7:0] b, logic bv, logic lst);
		while (!calm && $urandom_range(99) < 12) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= '{data_byte: b, byte_valid: bv, last: lst};
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		n_items++;
	endtask

	// drop valid for one cycle after the last accepted item
	task automatic go_idle();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// message of len random bytes; the end mark rides on the last byte or
	// comes as a separate end-only item
	task automatic send_message(int len, bit sep_end);
		for (int i = 0; i < len; i++)
			send_item(8'($urandom_range(255)), 1'b1, (i == len - 1) && !sep_end);
		if (sep_end || len == 0)
			send_item(8'($urandom_range(255)), 1'b0, 1'b1);
	endtask

	initial begin
		int len;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty message, noise item, extremes and pad boundaries
		send_item(8'h00, 1'b0, 1'b1);
		send_item(8'hff, 1'b0, 1'b0);	// no byte and no end: ignored
		send_item(8'hff, 1'b1, 1'b1);
		send_item(8'h00, 1'b1, 1'b0);
		send_item(8'h55, 1'b1, 1'b0);
		send_item(8'haa, 1'b1, 1'b1);
		send_message(3, 1'b1);
		foreach (len_list[i])
			send_message(len_list[i], 1'(len_list[i] % 2));

		// hold off until every digest word has drained
		go_idle();
		wait (pending == 0);
		repeat (20) @(posedge clk);

		// random: mostly short messages, some crossing block boundaries
		while (n_items < 480) begin
			calm = (n_items > 330 && n_items < 400);
			case ($urandom_range(9))
				0: len = $urandom_range(80);
				1: send_item(8'($urandom_range(255)), 1'b0, 1'b0);
				default: len = $urandom_range(12);
			endcase
			send_message(len, 1'($urandom_range(1)));
		end
		calm = 1'b0;
		go_idle();
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("Sent %0d items; %0d digests checked, padding boundaries included.",
			n_items, digests);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	initial begin
		#20ms;
		$display("DONE: errors detected");
		$finish;
	end
endmodule

### files.f
+incdir+src
src/sha_pkg.sv
src/sha_front.sv
src/sha_back.sv
src/sha256_hasher_unit.sv
tb/sha256_hasher_checker.sv
tb/tb_sha256_hasher_unit.sv
